### rtl/pnn_pkg.sv
// Package for the polygon normal block: payload types and shared constants.
`default_nettype none
package pnn_pkg;
	localparam int COORD_W = 16;
	localparam int OUT_W = 16;
	localparam int SUM_W = 48;
	localparam int MAG_W = 30;
	localparam int DEF_MAX_VERTICES = 256;
	localparam int DEF_NORMAL_FRAC_BITS = 14;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic last;
	} vertex_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_x;
		logic signed [OUT_W-1:0] normal_y;
		logic signed [OUT_W-1:0] normal_z;
		logic degenerate;
		logic overflow;
	} normal_t;
endpackage
`default_nettype wire

### rtl/polygon_normal_newell.sv
// Top level: polygon normal by Newell's method with iterative normalisation.
//
//  channel | dir | payload            | handshake
//  vtx     | in  | pnn_pkg::vertex_t  | vtx_valid / vtx_stall
//  nrm     | out | pnn_pkg::normal_t  | nrm_valid / nrm_stall
//
// Steps: a vertex is accepted, then takes four steps through the one shared multiplier; the
// first vertex of a polygon and a dropped vertex are only accepted. A last vertex adds the
// closing pair, the magnitude, the shift, the squaring, the square root, three divisions and
// the output step; a zero sum skips from magnitude straight to output.
// Reset clears the polygon state and the output valid. vtx_stall is high whenever a transaction
// is in work; a finished normal waits in the output register while the next polygon streams in.
`default_nettype none
module polygon_normal_newell #(
	parameter int MAX_VERTICES = pnn_pkg::DEF_MAX_VERTICES,
	parameter int NORMAL_FRAC_BITS = pnn_pkg::DEF_NORMAL_FRAC_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic vtx_valid,
	output logic vtx_stall,
	input wire pnn_pkg::vertex_t vtx,
	output logic nrm_valid,
	input wire logic nrm_stall,
	output pnn_pkg::normal_t nrm
);
	localparam int F = NORMAL_FRAC_BITS;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int Q_W = F + 1;
	localparam int DEN_W = pnn_pkg::MAG_W + 1;
	localparam int NUM_W = pnn_pkg::MAG_W + Q_W;
	localparam int SUM_W = pnn_pkg::SUM_W;
	localparam int SQ_W = 2 * pnn_pkg::MAG_W + 2;
	localparam int BIT_W = SQ_W - 1;
	localparam int OUT_W = pnn_pkg::OUT_W;
	localparam int COORD_W_L = pnn_pkg::COORD_W + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PAIR = 4'd1;
	localparam logic [3:0] ST_ABS = 4'd2;
	localparam logic [3:0] ST_SHIFT = 4'd3;
	localparam logic [3:0] ST_SQ = 4'd4;
	localparam logic [3:0] ST_SQRT = 4'd5;
	localparam logic [3:0] ST_DIVS = 4'd6;
	localparam logic [3:0] ST_DIVW = 4'd7;
	localparam logic [3:0] ST_FIN = 4'd8;

	logic [3:0] state_q;
	logic [1:0] step_q;
	logic [1:0] idx_q;
	logic close_q;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic deg_q;
	pnn_pkg::vertex_t vin_q;
	logic signed [pnn_pkg::COORD_W-1:0] fx_q, fy_q, fz_q, px_q, py_q, pz_q;
	logic [SUM_W-1:0] sum_q [3];
	logic [SUM_W-1:0] a_q [3];
	logic [2:0] sgn_q;
	logic [SUM_W-1:0] m_q;
	logic [SQ_W-1:0] l2_q;
	logic [SQ_W-1:0] r_q;
	logic [BIT_W-1:0] bit_q;
	logic [OUT_W-1:0] comp_q [3];
	logic [59:0] mul_q;
	pnn_pkg::normal_t nrm_q;
	logic nrm_valid_q;

	logic signed [COORD_W_L-1:0] dif [3];
	logic signed [COORD_W_L-1:0] sm [3];
	logic signed [pnn_pkg::COORD_W-1:0] bx, by, bz;
	logic signed [31:0] op_a, op_b;
	logic signed [63:0] prod;
	logic [SUM_W-1:0] mag [3];
	logic [SUM_W-1:0] mmax;
	logic [1:0] sel;
	logic [SQ_W:0] trial;
	logic [DEN_W-1:0] len;
	logic [NUM_W-1:0] div_num;
	logic div_start, div_done;
	logic [Q_W-1:0] div_quo;
	logic [Q_W-1:0] qc;
	logic [OUT_W-1:0] qt;
	logic vtx_acc, load_out;

	assign vtx_stall = state_q != ST_IDLE;
	assign vtx_acc = vtx_valid && !vtx_stall;
	assign load_out = state_q == ST_FIN && (!nrm_valid_q || !nrm_stall);
	assign nrm_valid = nrm_valid_q;
	assign nrm = nrm_q;

	always_comb begin
		bx = close_q ? fx_q : vin_q.x;
		by = close_q ? fy_q : vin_q.y;
		bz = close_q ? fz_q : vin_q.z;
		dif[0] = COORD_W_L'(py_q) - COORD_W_L'(by);
		sm[0] = COORD_W_L'(pz_q) + COORD_W_L'(bz);
		dif[1] = COORD_W_L'(pz_q) - COORD_W_L'(bz);
		sm[1] = COORD_W_L'(px_q) + COORD_W_L'(bx);
		dif[2] = COORD_W_L'(px_q) - COORD_W_L'(bx);
		sm[2] = COORD_W_L'(py_q) + COORD_W_L'(by);
		sel = (step_q == 2'd3) ? 2'd0 : step_q;
		if (state_q == ST_SQ) begin
			op_a = signed'({2'b00, a_q[sel][pnn_pkg::MAG_W-1:0]});
			op_b = op_a;
		end else begin
			op_a = 32'(dif[sel]);
			op_b = 32'(sm[sel]);
		end
		prod = op_a * op_b;
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag[i] = sum_q[i][SUM_W-1] ? SUM_W'(-sum_q[i]) : sum_q[i];
		mmax = mag[0];
		if (mag[1] > mmax)
			mmax = mag[1];
		if (mag[2] > mmax)
			mmax = mag[2];
	end

	assign trial = {1'b0, r_q} + {2'b00, bit_q};
	assign len = (r_q[DEN_W-1:0] == '0) ? DEN_W'(1) : r_q[DEN_W-1:0];
	assign div_num = (NUM_W'(a_q[idx_q][pnn_pkg::MAG_W-1:0]) << F) + NUM_W'(len >> 1);
	assign div_start = state_q == ST_DIVS;

	always_comb begin
		qc = (div_quo > Q_W'(1) << F) ? Q_W'(1) << F : div_quo;
		qt = OUT_W'(qc);
	end

	pnn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(len),
		.done(div_done),
		.quo(div_quo)
	);

	always_ff @(posedge clk) begin
		mul_q <= prod[59:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			idx_q <= '0;
			close_q <= 1'b0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			deg_q <= 1'b0;
			fx_q <= '0; fy_q <= '0; fz_q <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			for (int i = 0; i < 3; i++)
				sum_q[i] <= '0;
			nrm_valid_q <= 1'b0;
		end else begin
			if (load_out)
				nrm_valid_q <= 1'b1;
			else if (nrm_valid_q && !nrm_stall)
				nrm_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (vtx_acc) begin
						step_q <= '0;
						if (cnt_q == '0) begin
							fx_q <= vtx.x; fy_q <= vtx.y; fz_q <= vtx.z;
							px_q <= vtx.x; py_q <= vtx.y; pz_q <= vtx.z;
							cnt_q <= CNT_W'(1);
							if (vtx.last) begin
								close_q <= 1'b1;
								state_q <= ST_PAIR;
							end
						end else if (cnt_q < CNT_W'(MAX_VERTICES)) begin
							close_q <= 1'b0;
							state_q <= ST_PAIR;
						end else begin
							ovf_q <= 1'b1;
							if (vtx.last) begin
								close_q <= 1'b1;
								state_q <= ST_PAIR;
							end
						end
					end
				end
				ST_PAIR: begin
					step_q <= step_q + 1'b1;
					if (step_q != 2'd0)
						sum_q[step_q - 2'd1] <= sum_q[step_q - 2'd1] + mul_q[SUM_W-1:0];
					if (step_q == 2'd3) begin
						if (close_q) begin
							state_q <= ST_ABS;
						end else begin
							px_q <= vin_q.x; py_q <= vin_q.y; pz_q <= vin_q.z;
							cnt_q <= cnt_q + 1'b1;
							if (vin_q.last)
								close_q <= 1'b1;
							else
								state_q <= ST_IDLE;
						end
					end
				end
				ST_ABS: begin
					// drop straight to the result when all three sums cancel
					if (mmax == '0) begin
						deg_q <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						deg_q <= 1'b0;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (m_q[SUM_W-1:pnn_pkg::MAG_W] != '0) begin
						state_q <= ST_SHIFT;
					end else if (!m_q[pnn_pkg::MAG_W-1]) begin
						state_q <= ST_SHIFT;
					end else begin
						step_q <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3)
						state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (bit_q[0]) begin
						idx_q <= '0;
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						if (idx_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_DIVS;
						end
					end
				end
				ST_FIN: begin
					if (load_out) begin
						fx_q <= '0; fy_q <= '0; fz_q <= '0;
						px_q <= '0; py_q <= '0; pz_q <= '0;
						for (int i = 0; i < 3; i++)
							sum_q[i] <= '0;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						close_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers for normalisation
	always_ff @(posedge clk) begin
		if (vtx_acc)
			vin_q <= vtx;
		case (state_q)
			ST_ABS: begin
				for (int i = 0; i < 3; i++) begin
					a_q[i] <= mag[i];
					sgn_q[i] <= sum_q[i][SUM_W-1];
				end
				m_q <= mmax;
			end
			ST_SHIFT: begin
				if (m_q[SUM_W-1:pnn_pkg::MAG_W] != '0) begin
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] >> 1;
					m_q <= m_q >> 1;
				end else if (!m_q[pnn_pkg::MAG_W-1]) begin
					for (int i = 0; i < 3; i++)
						a_q[i] <= a_q[i] << 1;
					m_q <= m_q << 1;
				end
			end
			ST_SQ: begin
				if (step_q == 2'd1)
					l2_q <= SQ_W'(mul_q);
				else if (step_q != 2'd0)
					l2_q <= l2_q + SQ_W'(mul_q);
				r_q <= '0;
				bit_q <= BIT_W'(1) << (BIT_W - 1);
			end
			ST_SQRT: begin
				if ({1'b0, l2_q} >= trial) begin
					l2_q <= l2_q - SQ_W'(trial);
					r_q <= (r_q >> 1) + SQ_W'(bit_q);
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIVW: begin
				if (div_done)
					comp_q[idx_q] <= sgn_q[idx_q] ? OUT_W'(-qt) : qt;
			end
			default: ;
		endcase
		if (load_out) begin
			nrm_q.normal_x <= deg_q ? '0 : comp_q[0];
			nrm_q.normal_y <= deg_q ? '0 : comp_q[1];
			nrm_q.normal_z <= deg_q ? '0 : comp_q[2];
			nrm_q.degenerate <= deg_q;
			nrm_q.overflow <= ovf_q;
		end
	end
endmodule
`default_nettype wire

### rtl/pnn_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pnn_div #(
	parameter int NUM_W = 45,
	parameter int DEN_W = 31,
	parameter int Q_W = 15
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [NUM_W-1:0] num,
	input wire logic [DEN_W-1:0] den,
	output logic done,
	output logic [Q_W-1:0] quo
);
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0] nq_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [DEN_W:0] trial;
	logic fits;

	assign trial = {rem_q, nq_q[Q_W-1]};
	assign fits = trial >= {1'b0, den};
	assign quo = nq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[NUM_W-1:Q_W]);
			nq_q <= num[Q_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			nq_q <= {nq_q[Q_W-2:0], fits};
		end
	end
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for polygon_normal_newell: Newell normal prediction, random idling and stalls.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_VERTS = pnn_pkg::DEF_MAX_VERTICES;
	localparam int FRAC = pnn_pkg::DEF_NORMAL_FRAC_BITS;
	localparam int SUM_W = pnn_pkg::SUM_W;
	localparam int OUT_W = pnn_pkg::OUT_W;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vtx_valid = 1'b0;
	logic vtx_stall;
	pnn_pkg::vertex_t vtx = '0;
	logic nrm_valid;
	logic nrm_stall = 1'b0;
	pnn_pkg::normal_t nrm;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int errors = 0;
	int polygons_sent = 0;
	int normals_seen = 0;
	int quiet_cycles = 0;

	// polygon state mirrored from the block
	logic signed [63:0] first_v [3];
	logic signed [63:0] prev_v [3];
	logic [SUM_W-1:0] acc [3];
	int held_count = 0;
	bit dropped = 1'b0;
	pnn_pkg::normal_t pending_normals [$];

	polygon_normal_newell dut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.nrm_valid(nrm_valid), .nrm_stall(nrm_stall), .nrm(nrm)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void add_newell(input logic signed [63:0] a [3],
		input logic signed [63:0] b [3]);
		acc[0] += (a[1] - b[1]) * (a[2] + b[2]);
		acc[1] += (a[2] - b[2]) * (a[0] + b[0]);
		acc[2] += (a[0] - b[0]) * (a[1] + b[1]);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	task automatic predict_vertex(input pnn_pkg::vertex_t v);
		logic signed [63:0] cur [3];
		logic signed [63:0] s [3];
		logic [63:0] mg [3];
		logic [63:0] top, l2, len, q;
		int p;
		pnn_pkg::normal_t r;
		cur[0] = v.x; cur[1] = v.y; cur[2] = v.z;
		if (held_count == 0) begin
			first_v = cur;
			prev_v = cur;
			held_count = 1;
		end else if (held_count < MAX_VERTS) begin
			add_newell(prev_v, cur);
			prev_v = cur;
			held_count++;
		end else begin
			dropped = 1'b1;
		end
		if (!v.last) return;
		add_newell(prev_v, first_v);
		top = 0;
		for (int i = 0; i < 3; i++) begin
			s[i] = {{(64-SUM_W){acc[i][SUM_W-1]}}, acc[i]};
			mg[i] = s[i] < 0 ? -s[i] : s[i];
			if (mg[i] > top) top = mg[i];
		end
		r = '0;
		r.overflow = dropped;
		if (top == 0) begin
			r.degenerate = 1'b1;
		end else begin
			p = 0;
			while (p < 63 && (top >> (p + 1)) != 0) p++;
			for (int i = 0; i < 3; i++)
				mg[i] = p > 29 ? mg[i] >> (p - 29) : mg[i] << (29 - p);
			l2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
			len = int_sqrt(l2);
			if (len == 0) len = 1;
			for (int i = 0; i < 3; i++) begin
				q = ((mg[i] << FRAC) + (len >> 1)) / len;
				if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
				if (s[i] < 0) q = -q;
				case (i)
					0: r.normal_x = q[OUT_W-1:0];
					1: r.normal_y = q[OUT_W-1:0];
					default: r.normal_z = q[OUT_W-1:0];
				endcase
			end
		end
		pending_normals = {pending_normals, r};
		polygons_sent++;
		foreach (acc[i]) acc[i] = '0;
		held_count = 0;
		dropped = 1'b0;
	endtask

	// send one vertex; the sender may idle first, valid stays up until the next call
	task automatic send_vertex(input pnn_pkg::vertex_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_valid <= 1'b0;
			@(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx <= v;
		@(posedge clk);
		while (vtx_stall) @(posedge clk);
		predict_vertex(v);
	endtask

	function automatic pnn_pkg::vertex_t rand_vertex(input int range_bits, input bit fin);
		pnn_pkg::vertex_t v;
		int span;
		span = 1 << range_bits;
		v.x = $urandom_range(span - 1) - span / 2;
		v.y = $urandom_range(span - 1) - span / 2;
		v.z = $urandom_range(span - 1) - span / 2;
		if (range_bits == 16) begin
			v.x = $urandom; v.y = $urandom; v.z = $urandom;
		end
		v.last = fin;
		return v;
	endfunction

	task automatic send_polygon(input int n, input int range_bits);
		for (int i = 0; i < n; i++) send_vertex(rand_vertex(range_bits, i == n - 1));
	endtask

	// receiver: a requested long hold-off counts down here, otherwise random stalls
	always @(posedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD;
			nrm_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			nrm_stall <= 1'b1;
		end else begin
			nrm_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pnn_pkg::normal_t want;
		if (arst_n && nrm_valid && !nrm_stall) begin
			normals_seen++;
			if (pending_normals.size() == 0) begin
				$display("%0t: unexpected normal %p", $time, nrm);
				errors++;
			end else begin
				want = pending_normals.pop_front();
				if (nrm.normal_x !== want.normal_x || nrm.normal_y !== want.normal_y ||
						nrm.normal_z !== want.normal_z || nrm.degenerate !== want.degenerate ||
						nrm.overflow !== want.overflow) begin
					$display("%0t: normal mismatch expected %p actual %p", $time, want, nrm);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (nrm_valid && !nrm_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_directed();
		// right triangle in the xy plane, then one in the yz plane
		send_vertex('{x: 0, y: 0, z: 0, last: 0});
		send_vertex('{x: 100, y: 0, z: 0, last: 0});
		send_vertex('{x: 0, y: 100, z: 0, last: 1});
		send_vertex('{x: 0, y: 0, z: 0, last: 0});
		send_vertex('{x: 0, y: 0, z: 100, last: 0});
		send_vertex('{x: 0, y: 100, z: 0, last: 1});
		// single vertex and two vertices: degenerate
		send_vertex('{x: 16'sh7fff, y: 16'sh8000, z: 5, last: 1});
		send_vertex('{x: 1, y: 2, z: 3, last: 0});
		send_vertex('{x: -1, y: -2, z: -3, last: 1});
		// extremes of the coordinate range
		send_vertex('{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000, last: 0});
		send_vertex('{x: 16'sh7fff, y: 16'sh8000, z: 16'sh7fff, last: 0});
		send_vertex('{x: 16'sh7fff, y: 16'sh7fff, z: 16'sh8000, last: 0});
		send_vertex('{x: 16'shffff, y: 16'sh7fff, z: 16'sh0000, last: 1});
		// collinear points
		send_vertex('{x: 1, y: 1, z: 1, last: 0});
		send_vertex('{x: 2, y: 2, z: 2, last: 0});
		send_vertex('{x: 3, y: 3, z: 3, last: 1});
		// tiny triangle: magnitude shifted left
		send_vertex('{x: 0, y: 0, z: 0, last: 0});
		send_vertex('{x: 1, y: 0, z: 0, last: 0});
		send_vertex('{x: 0, y: 0, z: 1, last: 1});
	endtask

	task automatic test_overflow();
		// past the vertex limit with the marked vertex dropped, then at the limit with it kept
		send_polygon(MAX_VERTS + 5, 16);
		send_polygon(MAX_VERTS + 1, 10);
		send_polygon(MAX_VERTS, 12);
	endtask

	task automatic test_random(input int n_vertices);
		int sent;
		int n;
		sent = 0;
		while (sent < n_vertices) begin
			n = $urandom_range(99) < 70 ? $urandom_range(3, 6) : $urandom_range(1, 12);
			send_polygon(n, $urandom_range(99) < 60 ? 16 : $urandom_range(2, 12));
			sent += n;
		end
	endtask

	task automatic test_backpressure();
		// hold the receiver off and keep offering polygons until the input stalls
		hold_requests++;
		for (int k = 0; k < 3; k++) send_polygon(4, 16);
	endtask

	initial begin
		foreach (acc[i]) acc[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_overflow();
		test_random(80);
		send_idle_pct = 68;
		test_random(80);
		send_idle_pct = 0;
		recv_stall_pct = 68;
		test_random(80);
		send_idle_pct = 13;
		recv_stall_pct = 13;
		test_random(80);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(20);
		vtx_valid <= 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d polygons (%0d normals checked): triangles to over-limit",
			polygons_sent, normals_seen);
		$display("fans, coordinate extremes, degenerate shapes, idling and long stalls.");
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
